// ----- rtl/core/rnd_pkg.sv -----
// shared types and constants for the rtp nal depacketizer
`default_nettype none

package rnd_pkg;

    localparam logic [5:0] TYPE_MASK      = 6'b111111;
    localparam logic [5:0] TYPE_AGGREGATE = 6'd48;
    localparam logic [5:0] TYPE_FRAGMENT  = 6'd49;
    localparam int unsigned FU_FIRST_BIT  = 7;
    localparam int unsigned FU_LAST_BIT   = 6;

    localparam logic [1:0] KIND_SINGLE        = 2'd0;
    localparam logic [1:0] KIND_AGGREGATE     = 2'd1;
    localparam logic [1:0] KIND_FRAGMENT      = 2'd2;
    localparam logic [1:0] KIND_FRAGMENT_LAST = 2'd3;

    localparam logic [1:0] AGG_SIZE_HIGH = 2'd0;
    localparam logic [1:0] AGG_SIZE_LOW  = 2'd1;
    localparam logic [1:0] AGG_DATA      = 2'd2;

    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_FU     = 2'd1;
    localparam logic [1:0] POS_BEYOND = 2'd2;

    typedef struct packed {
        logic [15:0] seq_number;
        logic        packet_end;
        logic        packet_start;
        logic [7:0]  payload_byte;
    } t_item;

    typedef struct packed {
        logic [15:0] missed_packets;
        logic        abort_unit;
        logic        unit_last;
        logic        unit_first;
        logic        byte_valid;
        logic [7:0]  unit_byte;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/rtp_nal_depacketizer_core.sv -----
// Depacketizer top level: input register, per-byte decode, result register.
// Takes one rtp payload byte per cycle, stalled while a byte's result meets a full result
// register, and returns at most one result per byte via the input and result registers;
// the rate is set by the single decode step between them, which updates the packet state
// once per byte. Late packets (lower sequence number, no wrap) are dropped whole, and a
// header result carries the count of skipped sequence numbers or an abort of an open unit.
`default_nettype none

module rtp_nal_depacketizer_core
    import rnd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // payload_byte, seq_number
    input  wire logic        s_axis_tlast,  // packet_end
    input  wire logic [0:0]  s_axis_tuser,  // packet_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // unit_byte, missed_packets
    output logic             m_axis_tlast,  // unit_last
    output logic [2:0]       m_axis_tuser   // byte_valid, unit_first, abort_unit
);

    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result res;
    logic    res_valid;
    logic    out_free;
    logic    step;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && (!res_valid || out_free);
    assign s_axis_tready = !r_in_valid || step;

    rnd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (r_in),
        .i_step      (step),
        .o_result    (res),
        .o_res_valid (res_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.payload_byte <= s_axis_tdata[7:0];
            r_in.seq_number   <= s_axis_tdata[23:8];
            r_in.packet_end   <= s_axis_tlast;
            r_in.packet_start <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.missed_packets, r_out.unit_byte};
    assign m_axis_tlast  = r_out.unit_last;
    assign m_axis_tuser  = {r_out.abort_unit, r_out.unit_first, r_out.byte_valid};

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid && $stable(r_in))
        else $error("input item lost while waiting");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("data byte set on a marker result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && res_valid |-> out_free)
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/rnd_parse.sv -----
// per-byte packet state and result decode
`default_nettype none

module rnd_parse
    import rnd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_item   i_item,
    input  wire logic    i_step,
    output t_result      o_result,
    output logic         o_res_valid
);

    logic [15:0] r_last_seq, n_last_seq;
    logic        r_drop, n_drop;
    logic [1:0]  r_pos, n_pos;
    logic [1:0]  r_kind, n_kind;
    logic        r_frag_open, n_frag_open;
    logic [1:0]  r_agg, n_agg;
    logic [15:0] r_remaining, n_remaining;
    logic        r_unit_open, n_unit_open;
    logic [7:0]  r_size_high, n_size_high;

    logic [7:0]  b;
    logic        st;
    logic        en;
    logic [16:0] last_inc;
    logic [15:0] missed;
    logic [1:0]  kind;
    logic        ab;
    logic        uo;
    logic [15:0] rem_dec;
    logic        fu_first;
    logic        fu_last;
    logic [15:0] size;

    assign b        = i_item.payload_byte;
    assign st       = i_item.packet_start;
    assign en       = i_item.packet_end;
    assign last_inc = {1'b0, r_last_seq} + 17'd1;
    assign missed   = ({1'b0, i_item.seq_number} > last_inc) ?
                      (i_item.seq_number - r_last_seq - 16'd1) : 16'd0;
    assign kind     = ((b[5:0] & TYPE_MASK) == TYPE_AGGREGATE) ? KIND_AGGREGATE :
                      ((b[5:0] & TYPE_MASK) == TYPE_FRAGMENT)  ? KIND_FRAGMENT :
                      KIND_SINGLE;
    assign rem_dec  = r_remaining - 16'd1;
    assign fu_first = b[FU_FIRST_BIT];
    assign fu_last  = b[FU_LAST_BIT];
    assign size     = {r_size_high, b};

    always_comb begin
        n_last_seq  = r_last_seq;
        n_drop      = r_drop;
        n_pos       = r_pos;
        n_kind      = r_kind;
        n_frag_open = r_frag_open;
        n_agg       = r_agg;
        n_remaining = r_remaining;
        n_unit_open = r_unit_open;
        n_size_high = r_size_high;
        o_result    = '0;
        o_res_valid = 1'b0;
        ab          = 1'b0;
        uo          = r_unit_open;

        if (st) begin
            n_pos  = POS_HEADER;
            n_agg  = AGG_SIZE_HIGH;
            n_drop = 1'b0;
            if (i_item.seq_number < r_last_seq) begin
                n_drop = !en;
            end else begin
                n_last_seq = i_item.seq_number;
                if (kind != KIND_FRAGMENT || en || !r_frag_open) begin
                    ab          = r_unit_open;
                    n_unit_open = 1'b0;
                    if (kind != KIND_FRAGMENT || en) begin
                        n_frag_open = 1'b0;
                    end
                end
                n_kind = kind;
                n_pos  = en ? POS_HEADER : POS_FU;
                if (ab || missed != 16'd0) begin
                    o_res_valid             = 1'b1;
                    o_result.abort_unit     = ab;
                    o_result.missed_packets = missed;
                end
            end
        end else if (r_drop) begin
            if (en) begin
                n_drop = 1'b0;
                n_pos  = POS_HEADER;
            end
        end else if (r_pos != POS_HEADER) begin
            if (r_pos == POS_FU) begin
                n_pos = POS_BEYOND;
            end
            case (r_kind)
                KIND_SINGLE: begin
                    n_unit_open         = !en;
                    o_res_valid         = 1'b1;
                    o_result.unit_byte  = b;
                    o_result.byte_valid = 1'b1;
                    o_result.unit_first = !r_unit_open;
                    o_result.unit_last  = en;
                end
                KIND_AGGREGATE: begin
                    case (r_agg)
                        AGG_SIZE_HIGH: begin
                            n_size_high = b;
                            n_agg       = AGG_SIZE_LOW;
                        end
                        AGG_SIZE_LOW: begin
                            if (size != 16'd0) begin
                                n_remaining = size;
                                n_agg       = AGG_DATA;
                            end else begin
                                n_agg = AGG_SIZE_HIGH;
                            end
                        end
                        default: begin
                            n_remaining         = rem_dec;
                            n_unit_open         = (rem_dec != 16'd0) && !en;
                            if (rem_dec == 16'd0) begin
                                n_agg = AGG_SIZE_HIGH;
                            end
                            o_res_valid         = 1'b1;
                            o_result.unit_byte  = b;
                            o_result.byte_valid = 1'b1;
                            o_result.unit_first = !r_unit_open;
                            o_result.unit_last  = (rem_dec == 16'd0);
                            o_result.abort_unit = en && (rem_dec != 16'd0);
                        end
                    endcase
                    if (en) begin
                        n_agg = AGG_SIZE_HIGH;
                    end
                end
                default: begin
                    if (r_pos == POS_FU) begin
                        if (fu_first && r_frag_open) begin
                            ab = r_unit_open;
                            uo = 1'b0;
                        end
                        n_frag_open = 1'b1;
                        n_kind      = fu_last ? KIND_FRAGMENT_LAST : KIND_FRAGMENT;
                        n_unit_open = uo;
                        if (en && fu_last) begin
                            if (uo) begin
                                o_res_valid        = 1'b1;
                                o_result.unit_last = 1'b1;
                            end else if (ab) begin
                                o_res_valid         = 1'b1;
                                o_result.abort_unit = 1'b1;
                            end
                            n_unit_open = 1'b0;
                            n_frag_open = 1'b0;
                        end else if (ab) begin
                            o_res_valid         = 1'b1;
                            o_result.abort_unit = 1'b1;
                        end
                    end else begin
                        n_unit_open = !(en && r_kind == KIND_FRAGMENT_LAST);
                        if (en && r_kind == KIND_FRAGMENT_LAST) begin
                            n_frag_open = 1'b0;
                        end
                        o_res_valid         = 1'b1;
                        o_result.unit_byte  = b;
                        o_result.byte_valid = 1'b1;
                        o_result.unit_first = !r_unit_open;
                        o_result.unit_last  = en && r_kind == KIND_FRAGMENT_LAST;
                    end
                end
            endcase
            if (en) begin
                n_pos = POS_HEADER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq  <= '0;
            r_drop      <= 1'b0;
            r_pos       <= POS_HEADER;
            r_kind      <= KIND_SINGLE;
            r_frag_open <= 1'b0;
            r_agg       <= AGG_SIZE_HIGH;
            r_remaining <= '0;
            r_unit_open <= 1'b0;
            r_size_high <= '0;
        end else if (i_step) begin
            r_last_seq  <= n_last_seq;
            r_drop      <= n_drop;
            r_pos       <= n_pos;
            r_kind      <= n_kind;
            r_frag_open <= n_frag_open;
            r_agg       <= n_agg;
            r_remaining <= n_remaining;
            r_unit_open <= n_unit_open;
            r_size_high <= n_size_high;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == POS_HEADER |-> !(r_pos == POS_HEADER && r_drop && r_agg == AGG_DATA))
        else $error("drop with aggregate data phase");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.unit_first |-> o_result.byte_valid)
        else $error("unit start without data");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.missed_packets != 16'd0 |-> !o_result.byte_valid)
        else $error("missed count on a data result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_last_seq) && $stable(r_unit_open))
        else $error("state moved without a step");
`endif

endmodule

`default_nettype wire
